// File: rtl/slc_pkg.sv
// ---------------------------------------------------------------------------
// slc_pkg: shared types and constants of the set-associative cache model
// Field widths, access mode and outcome codes, register indexes, sequencer
// states and the status word of the way scan unit.
// ---------------------------------------------------------------------------
package slc_pkg;

    // Fixed field widths
    localparam int ADDR_W     = 64;
    localparam int MODE_W     = 2;
    localparam int OUTCOME_W  = 2;
    localparam int COUNT_W    = 32;
    localparam int TAG_W      = 62;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int WAYS_W     = 4;
    localparam int SETB_W     = 3;
    localparam int BLKB_W     = 6;

    // Access modes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_IFETCH = 2'd3;

    // Lookup outcomes
    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SCAN,
        ST_UPDATE,
        ST_WRITE
    } t_state;

    // Status of the way scan unit
    typedef struct packed {
        logic done;
        logic hit;
        logic free_found;
    } t_scan_status;

endpackage

// File: rtl/slc_ram.sv
// ---------------------------------------------------------------------------
// slc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/slc_way_scan.sv
// ---------------------------------------------------------------------------
// slc_way_scan: iterative way scan of one cache set
// Visits one way per step with a single tag and stamp comparator, and keeps
// the hit way, the highest free way and the oldest-stamp victim.
// ---------------------------------------------------------------------------
module slc_way_scan #(
    parameter int MAX_WAYS    = 8,
    parameter int STAMP_WIDTH = 32
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_start,
    input  logic                                           i_step,
    input  logic [MAX_WAYS*(1+slc_pkg::TAG_W+STAMP_WIDTH)-1:0] i_row,
    input  logic [slc_pkg::TAG_W-1:0]                      i_tag,
    input  logic [slc_pkg::WAYS_W-1:0]                     i_ways,
    output slc_pkg::t_scan_status                          o_status,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] o_way
);

    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_BITS = 1 + slc_pkg::TAG_W + STAMP_WIDTH;

    logic [WAY_BITS-1:0]    w_entry [MAX_WAYS];
    logic [WAY_BITS-1:0]    w_cur;
    logic                   w_valid;
    logic [slc_pkg::TAG_W-1:0] w_tag;
    logic [STAMP_WIDTH-1:0] w_stamp;
    logic                   w_last;

    logic [WAY_W-1:0]       r_way;
    logic                   r_done;
    logic                   r_hit;
    logic [WAY_W-1:0]       r_hit_way;
    logic                   r_free_found;
    logic [WAY_W-1:0]       r_free_way;
    logic                   r_vic_found;
    logic [WAY_W-1:0]       r_vic_way;
    logic [STAMP_WIDTH-1:0] r_vic_stamp;

    // Split the row into ways: valid, tag, stamp from the top down
    for (genvar g = 0; g < MAX_WAYS; g++) begin : g_split
        assign w_entry[g] = i_row[g*WAY_BITS +: WAY_BITS];
    end

    assign w_cur   = w_entry[r_way];
    assign w_valid = w_cur[WAY_BITS-1];
    assign w_tag   = w_cur[STAMP_WIDTH +: slc_pkg::TAG_W];
    assign w_stamp = w_cur[STAMP_WIDTH-1:0];
    assign w_last  = (32'(r_way) + 32'd1 >= 32'(i_ways)) || (32'(r_way) == MAX_WAYS - 1);

    // Step through the ways, one compare per cycle while i_step is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_way        <= '0;
            r_done       <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end else if (i_start) begin
            r_way        <= '0;
            r_done       <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end else if (i_step && !r_done) begin
            if (!w_valid) begin
                r_free_found <= 1'b1;
                r_free_way   <= r_way;
            end else if (w_tag == i_tag) begin
                r_hit     <= 1'b1;
                r_hit_way <= r_way;
            end else if (!r_vic_found || r_vic_stamp > w_stamp) begin
                r_vic_found <= 1'b1;
                r_vic_way   <= r_way;
                r_vic_stamp <= w_stamp;
            end
            if (w_last || (w_valid && w_tag == i_tag)) begin
                r_done <= 1'b1;
            end else begin
                r_way <= r_way + WAY_W'(1);
            end
        end
    end

    // Report the way to write: hit, else free, else victim
    always_comb begin
        o_status.done       = r_done;
        o_status.hit        = r_hit;
        o_status.free_found = r_free_found;
        priority if (r_hit) begin
            o_way = r_hit_way;
        end else if (r_free_found) begin
            o_way = r_free_way;
        end else begin
            o_way = r_vic_way;
        end
    end

endmodule

// File: rtl/set_assoc_lru_cache_sim_core.sv
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core: set-associative cache model, LRU replacement
// Input items carry an address and an access mode; each lookup gives one
// result item with its outcome and saturating hit, miss and eviction totals.
// The input channel (i_in_valid / o_in_stall) takes one item at a time. A
// load or store makes one lookup, a modify makes two on the same set (the
// second result has o_last high), an instruction fetch is taken while idle
// and gives nothing. The first lookup of an item runs from acceptance through
// set read, row load, a scan of the ways one at a time through the shared tag
// and stamp comparator (the scan stops at a hit), a done check, the update
// and the write-back with the result registered. The second lookup of a
// modify reuses the loaded row and runs again from the scan. The input is
// free again once the sequencer returns to idle after the last write-back.
// A set is held as one RAM row: one read per item, written back by each lookup.
// Results wait in an output register (o_out_valid / i_out_stall); while the
// receiver stalls a full register the write-back state holds.
// After reset a clearing pass zeroes all 2**MAX_SET_BITS rows, one per cycle,
// with the input stalled; configuration writes are taken at any
// time through i_cfg_we / i_cfg_index / i_cfg_data and clamped on write.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_sim_core #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int STAMP_WIDTH  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [slc_pkg::ADDR_W-1:0]        i_address,
    input  logic [slc_pkg::MODE_W-1:0]        i_mode,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [slc_pkg::OUTCOME_W-1:0]     o_outcome,
    output logic [slc_pkg::COUNT_W-1:0]       o_hit_total,
    output logic [slc_pkg::COUNT_W-1:0]       o_miss_total,
    output logic [slc_pkg::COUNT_W-1:0]       o_eviction_total,
    output logic                              o_last,
    // Configuration port
    input  logic                              i_cfg_we,
    input  logic [slc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SET_W    = MAX_SET_BITS;
    localparam int DEPTH    = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_BITS = 1 + slc_pkg::TAG_W + STAMP_WIDTH;
    localparam int ROW_W    = MAX_WAYS * WAY_BITS;

    function automatic logic [slc_pkg::COUNT_W-1:0] sat_inc(
        input logic [slc_pkg::COUNT_W-1:0] v
    );
        return (v == '1) ? v : v + slc_pkg::COUNT_W'(1);
    endfunction

    slc_pkg::t_state r_state;
    slc_pkg::t_state n_state;

    // Configuration
    logic [slc_pkg::SETB_W-1:0] r_set_bits;
    logic [slc_pkg::BLKB_W-1:0] r_block_bits;
    logic [slc_pkg::WAYS_W-1:0] r_ways;
    logic [slc_pkg::SETB_W-1:0] w_cfg_setb;
    logic [slc_pkg::WAYS_W-1:0] w_cfg_ways;

    // Item and lookup state
    logic [SET_W-1:0]           r_set;
    logic [slc_pkg::TAG_W-1:0]  r_tag;
    logic [slc_pkg::MODE_W-1:0] r_mode;
    logic                       r_second;
    logic [ROW_W-1:0]           r_row;
    logic [STAMP_WIDTH-1:0]     r_clock;
    logic [slc_pkg::OUTCOME_W-1:0] r_outcome;
    logic [slc_pkg::COUNT_W-1:0] r_hit_cnt;
    logic [slc_pkg::COUNT_W-1:0] r_miss_cnt;
    logic [slc_pkg::COUNT_W-1:0] r_evict_cnt;
    logic [SET_W-1:0]           r_clr_idx;

    // Result register
    logic                          r_out_valid;
    logic [slc_pkg::OUTCOME_W-1:0] r_out_outcome;
    logic [slc_pkg::COUNT_W-1:0]   r_out_hit;
    logic [slc_pkg::COUNT_W-1:0]   r_out_miss;
    logic [slc_pkg::COUNT_W-1:0]   r_out_evict;
    logic                          r_out_last;

    // Address split
    logic [6:0]                 w_shift_sum;
    logic [slc_pkg::ADDR_W-1:0] w_set_sh;
    logic [slc_pkg::ADDR_W-1:0] w_tag_sh;
    logic [SET_W-1:0]           w_set_mask;
    logic [SET_W-1:0]           w_set;
    logic [slc_pkg::TAG_W-1:0]  w_tag;

    // Control
    logic                  w_in_accept;
    logic                  w_out_free;
    logic                  w_out_load;
    logic                  w_res_last;
    logic                  w_more;
    logic                  w_scan_start;
    logic                  w_scan_step;
    slc_pkg::t_scan_status w_scan;
    logic [WAY_W-1:0]      w_way;

    // RAM port signals
    logic             w_ram_we;
    logic [SET_W-1:0] w_ram_waddr;
    logic [ROW_W-1:0] w_ram_wdata;
    logic             w_ram_re;
    logic [ROW_W-1:0] w_ram_rdata;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_more      = (r_mode == slc_pkg::MODE_MODIFY) && !r_second;
    assign w_res_last  = !w_more;

    // Clamp configuration values into their ranges
    always_comb begin
        w_cfg_setb = i_cfg_data[slc_pkg::SETB_W-1:0];
        if (w_cfg_setb == '0) begin
            w_cfg_setb = slc_pkg::SETB_W'(1);
        end else if (32'(w_cfg_setb) > MAX_SET_BITS) begin
            w_cfg_setb = slc_pkg::SETB_W'(MAX_SET_BITS);
        end
        w_cfg_ways = i_cfg_data[slc_pkg::WAYS_W-1:0];
        if (w_cfg_ways == '0) begin
            w_cfg_ways = slc_pkg::WAYS_W'(1);
        end else if (32'(w_cfg_ways) > MAX_WAYS) begin
            w_cfg_ways = slc_pkg::WAYS_W'(MAX_WAYS);
        end
    end

    // Take configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= slc_pkg::SETB_W'(1);
            r_block_bits <= slc_pkg::BLKB_W'(1);
            r_ways       <= slc_pkg::WAYS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                slc_pkg::CFG_SET_BITS: r_set_bits <= w_cfg_setb;
                slc_pkg::CFG_BLOCK_BITS: begin
                    r_block_bits <= (i_cfg_data == '0) ? slc_pkg::BLKB_W'(1) : i_cfg_data;
                end
                slc_pkg::CFG_WAYS: r_ways <= w_cfg_ways;
                default: ;
            endcase
        end
    end

    // Split the address into set index and tag
    always_comb begin
        w_shift_sum = 7'(r_set_bits) + 7'(r_block_bits);
        w_set_sh    = i_address >> r_block_bits;
        w_tag_sh    = i_address >> w_shift_sum;
        for (int i = 0; i < SET_W; i++) begin
            w_set_mask[i] = (i < 32'(r_set_bits));
        end
        w_set = w_set_sh[SET_W-1:0] & w_set_mask;
        w_tag = (w_shift_sum >= 7'd64) ? '0 : w_tag_sh[slc_pkg::TAG_W-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slc_pkg::ST_CLEAR: begin
                if (r_clr_idx == SET_W'(DEPTH - 1)) begin
                    n_state = slc_pkg::ST_IDLE;
                end
            end
            slc_pkg::ST_IDLE: begin
                if (w_in_accept && i_mode != slc_pkg::MODE_IFETCH) begin
                    n_state = slc_pkg::ST_READ;
                end
            end
            slc_pkg::ST_READ:   n_state = slc_pkg::ST_LOAD;
            slc_pkg::ST_LOAD:   n_state = slc_pkg::ST_SCAN;
            slc_pkg::ST_SCAN: begin
                if (w_scan.done) begin
                    n_state = slc_pkg::ST_UPDATE;
                end
            end
            slc_pkg::ST_UPDATE: n_state = slc_pkg::ST_WRITE;
            slc_pkg::ST_WRITE: begin
                if (w_out_free) begin
                    n_state = w_more ? slc_pkg::ST_SCAN : slc_pkg::ST_IDLE;
                end
            end
            default: n_state = slc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall   = (r_state != slc_pkg::ST_IDLE);
        w_ram_we     = (r_state == slc_pkg::ST_CLEAR) || (r_state == slc_pkg::ST_WRITE);
        w_ram_waddr  = (r_state == slc_pkg::ST_CLEAR) ? r_clr_idx : r_set;
        w_ram_wdata  = (r_state == slc_pkg::ST_CLEAR) ? '0 : r_row;
        w_ram_re     = (r_state == slc_pkg::ST_READ);
        w_out_load   = (r_state == slc_pkg::ST_WRITE) && w_out_free;
        w_scan_start = (r_state == slc_pkg::ST_LOAD) || (w_out_load && w_more);
        w_scan_step  = (r_state == slc_pkg::ST_SCAN) && !w_scan.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Clearing pass index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (r_state == slc_pkg::ST_CLEAR) begin
            r_clr_idx <= r_clr_idx + SET_W'(1);
        end
    end

    // Capture the item and advance the access clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock  <= '0;
            r_second <= 1'b0;
        end else begin
            if (w_in_accept && i_mode != slc_pkg::MODE_IFETCH) begin
                r_second <= 1'b0;
                if (r_clock != '1) begin
                    r_clock <= r_clock + STAMP_WIDTH'(1);
                end
            end else if (w_out_load) begin
                r_second <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_set  <= w_set;
            r_tag  <= w_tag;
            r_mode <= i_mode;
        end
    end

    // Load the set row, then refresh the chosen way in place
    always_ff @(posedge i_clk) begin
        if (r_state == slc_pkg::ST_LOAD) begin
            r_row <= w_ram_rdata;
        end else if (r_state == slc_pkg::ST_UPDATE) begin
            r_row[w_way*WAY_BITS +: WAY_BITS] <= {1'b1, r_tag, r_clock};
        end
    end

    // Outcome and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else if (r_state == slc_pkg::ST_UPDATE) begin
            if (w_scan.hit) begin
                r_hit_cnt <= sat_inc(r_hit_cnt);
            end else begin
                r_miss_cnt <= sat_inc(r_miss_cnt);
                if (!w_scan.free_found) begin
                    r_evict_cnt <= sat_inc(r_evict_cnt);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == slc_pkg::ST_UPDATE) begin
            priority if (w_scan.hit) begin
                r_outcome <= slc_pkg::OUT_HIT;
            end else if (w_scan.free_found) begin
                r_outcome <= slc_pkg::OUT_MISS;
            end else begin
                r_outcome <= slc_pkg::OUT_EVICT;
            end
        end
    end

    // Result register: load when free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_outcome <= r_outcome;
            r_out_hit     <= r_hit_cnt;
            r_out_miss    <= r_miss_cnt;
            r_out_evict   <= r_evict_cnt;
            r_out_last    <= w_res_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_outcome        = r_out_outcome;
    assign o_hit_total      = r_out_hit;
    assign o_miss_total     = r_out_miss;
    assign o_eviction_total = r_out_evict;
    assign o_last           = r_out_last;

    // Line store: one row per set
    slc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_set),
        .o_rdata (w_ram_rdata)
    );

    // Shared way comparator
    slc_way_scan #(
        .MAX_WAYS    (MAX_WAYS),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_scan_start),
        .i_step   (w_scan_step),
        .i_row    (r_row),
        .i_tag    (r_tag),
        .i_ways   (r_ways),
        .o_status (w_scan),
        .o_way    (w_way)
    );

    // No result may appear during the clearing pass
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slc_pkg::ST_CLEAR) |-> !r_out_valid)
        else $error("result valid during clearing pass");

    // Hit total never falls
    a_hit_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_hit_cnt >= $past(r_hit_cnt)))
        else $error("hit total decreased");

    // Update only with a finished scan
    a_update_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slc_pkg::ST_UPDATE) |-> w_scan.done)
        else $error("update before way scan finished");

    // Only a modify gives a result that is not the last of its item
    a_first_only_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && !w_res_last) |-> (r_mode == slc_pkg::MODE_MODIFY))
        else $error("non-final result for a single-lookup item");

endmodule

// File: tb/set_assoc_lru_cache_sim_core_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core_checker: lookup predictor and result scoreboard
// Watches the configuration port and both channels of the cache model. Each
// accepted access item is run through a private copy of the cache (lines,
// stamps, access clock, totals) and its lookup results are queued; each
// accepted result item is compared field by field with the oldest entry.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_sim_core_checker #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int STAMP_WIDTH  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [slc_pkg::ADDR_W-1:0]     i_address,
    input  logic [slc_pkg::MODE_W-1:0]     i_mode,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [slc_pkg::OUTCOME_W-1:0]  i_outcome,
    input  logic [slc_pkg::COUNT_W-1:0]    i_hit_total,
    input  logic [slc_pkg::COUNT_W-1:0]    i_miss_total,
    input  logic [slc_pkg::COUNT_W-1:0]    i_eviction_total,
    input  logic                           i_last,
    input  logic                           i_cfg_we,
    input  logic [slc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);

    localparam int NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;

    typedef struct packed {
        logic [slc_pkg::OUTCOME_W-1:0] outcome;
        logic [slc_pkg::COUNT_W-1:0]   hits;
        logic [slc_pkg::COUNT_W-1:0]   misses;
        logic [slc_pkg::COUNT_W-1:0]   evictions;
        logic                          last;
    } t_lookup_result;

    // Expected lookup results, oldest first
    t_lookup_result pending_lookups[$];

    // Private copy of the cache
    bit                          line_valid [NUM_LINES];
    logic [slc_pkg::TAG_W-1:0]   line_tag   [NUM_LINES];
    logic [STAMP_WIDTH-1:0]      line_stamp [NUM_LINES];
    logic [STAMP_WIDTH-1:0]      access_clock;
    logic [slc_pkg::COUNT_W-1:0] hit_count;
    logic [slc_pkg::COUNT_W-1:0] miss_count;
    logic [slc_pkg::COUNT_W-1:0] evict_count;

    // Clamped register values
    int unsigned set_bits_eff;
    int unsigned block_bits_eff;
    int unsigned ways_eff;

    function automatic logic [slc_pkg::COUNT_W-1:0] bump(logic [slc_pkg::COUNT_W-1:0] value);
        return (value == '1) ? value : value + slc_pkg::COUNT_W'(1);
    endfunction

    // Look the tag up in one set and update lines and totals
    function automatic logic [slc_pkg::OUTCOME_W-1:0] probe_set(int unsigned set_idx,
                                                              logic [slc_pkg::TAG_W-1:0] tag);
        int  base;
        int  idx;
        int  free_way;
        int  victim;
        bit  victim_found;
        base         = set_idx * MAX_WAYS;
        free_way     = -1;
        victim       = 0;
        victim_found = 1'b0;
        for (int w = 0; w < ways_eff; w++) begin
            idx = base + w;
            if (!line_valid[idx]) begin
                free_way = w;
            end else begin
                if (line_tag[idx] == tag) begin
                    line_stamp[idx] = access_clock;
                    hit_count       = bump(hit_count);
                    return slc_pkg::OUT_HIT;
                end
                // keep the lowest way among equal oldest stamps
                if (!victim_found || line_stamp[base + victim] > line_stamp[idx]) begin
                    victim       = w;
                    victim_found = 1'b1;
                end
            end
        end
        miss_count = bump(miss_count);
        if (free_way >= 0) begin
            idx = base + free_way;
        end else begin
            idx         = base + victim;
            evict_count = bump(evict_count);
        end
        line_valid[idx] = 1'b1;
        line_tag[idx]   = tag;
        line_stamp[idx] = access_clock;
        return (free_way >= 0) ? slc_pkg::OUT_MISS : slc_pkg::OUT_EVICT;
    endfunction

    // Work out the results of one access item and queue them
    function automatic void predict_access(logic [slc_pkg::ADDR_W-1:0] addr,
                                           logic [slc_pkg::MODE_W-1:0] mode);
        logic [slc_pkg::ADDR_W-1:0] set_sel;
        logic [slc_pkg::TAG_W-1:0]  tag;
        int unsigned                shift;
        t_lookup_result             res;
        if (mode == slc_pkg::MODE_IFETCH)
            return;
        shift   = set_bits_eff + block_bits_eff;
        set_sel = (addr >> block_bits_eff) & ((64'd1 << set_bits_eff) - 64'd1);
        tag     = (shift >= slc_pkg::ADDR_W) ? '0 : slc_pkg::TAG_W'(addr >> shift);
        if (access_clock != '1)
            access_clock = access_clock + STAMP_WIDTH'(1);
        res.outcome   = probe_set(int'(set_sel), tag);
        res.hits      = hit_count;
        res.misses    = miss_count;
        res.evictions = evict_count;
        res.last      = (mode != slc_pkg::MODE_MODIFY);
        pending_lookups.push_back(res);
        if (mode == slc_pkg::MODE_MODIFY) begin
            // second lookup of a modify shares the stamp of the first
            res.outcome   = probe_set(int'(set_sel), tag);
            res.hits      = hit_count;
            res.misses    = miss_count;
            res.evictions = evict_count;
            res.last      = 1'b1;
            pending_lookups.push_back(res);
        end
    endfunction

    function automatic void check_field(string name, logic [slc_pkg::COUNT_W-1:0] want,
                                        logic [slc_pkg::COUNT_W-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_lookup_result want;
        int unsigned    field;
        if (!i_rst_n) begin
            // clear the private cache, the tallies and any expectation
            for (int i = 0; i < NUM_LINES; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_stamp[i] = '0;
            end
            access_clock   = '0;
            hit_count      = '0;
            miss_count     = '0;
            evict_count    = '0;
            set_bits_eff   = 1;
            block_bits_eff = 1;
            ways_eff       = 1;
            o_fail_count   = 0;
            o_checked      = 0;
            pending_lookups.delete();
        end else begin
            // mirror register writes, clamped as the block does
            if (i_cfg_we) begin
                case (i_cfg_index)
                    slc_pkg::CFG_SET_BITS: begin
                        field = 32'(i_cfg_data & 6'h07);
                        if (field < 1) field = 1;
                        if (field > MAX_SET_BITS) field = MAX_SET_BITS;
                        set_bits_eff = field;
                    end
                    slc_pkg::CFG_BLOCK_BITS: begin
                        field = 32'(i_cfg_data);
                        if (field < 1) field = 1;
                        block_bits_eff = field;
                    end
                    slc_pkg::CFG_WAYS: begin
                        field = 32'(i_cfg_data & 6'h0F);
                        if (field < 1) field = 1;
                        if (field > MAX_WAYS) field = MAX_WAYS;
                        ways_eff = field;
                    end
                    default: ;
                endcase
            end
            // compare a result item before queueing a newer access
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (pending_lookups.size() == 0) begin
                    o_fail_count++;
                    $display("%0t ns: result expected none, got outcome %0d hits %0d",
                             $time, i_outcome, i_hit_total);
                end else begin
                    want = pending_lookups.pop_front();
                    check_field("outcome", 32'(want.outcome), 32'(i_outcome));
                    check_field("hit_total", want.hits, i_hit_total);
                    check_field("miss_total", want.misses, i_miss_total);
                    check_field("eviction_total", want.evictions, i_eviction_total);
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_access(i_address, i_mode);
        end
        o_pending = pending_lookups.size();
    end

endmodule

// File: tb/set_assoc_lru_cache_sim_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core_tb: testbench of the cache model
// A directed run over clamped and extreme cache shapes, then random phases:
// each phase sets a new shape and sends accesses drawn from a small tag pool
// over a few hot sets, so hits, fills and evictions all occur, with some
// fully random addresses mixed in. Both sides idle in random bursts.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_sim_core_tb;

    localparam int MAX_SET_BITS  = 6;
    localparam int MAX_WAYS      = 8;
    localparam int STAMP_WIDTH   = 32;
    localparam int TARGET_ITEMS  = 1650;
    localparam int QUIET_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 1000000;

    // index past the register list; writes to it are ignored
    localparam logic [slc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    logic [slc_pkg::ADDR_W-1:0]     i_address   = '0;
    logic [slc_pkg::MODE_W-1:0]     i_mode      = slc_pkg::MODE_LOAD;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [slc_pkg::OUTCOME_W-1:0]  o_outcome;
    logic [slc_pkg::COUNT_W-1:0]    o_hit_total;
    logic [slc_pkg::COUNT_W-1:0]    o_miss_total;
    logic [slc_pkg::COUNT_W-1:0]    o_eviction_total;
    logic                           o_last;
    logic                           i_cfg_we    = 1'b0;
    logic [slc_pkg::CFG_IDX_W-1:0]  i_cfg_index = slc_pkg::CFG_SET_BITS;
    logic [slc_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int lookups_pending;
    int results_checked;

    int cycle_count = 0;
    int items_sent  = 0;
    int shapes_run  = 0;
    bit idle_en     = 1'b0;

    // shape in force and the address pool of the current phase
    int unsigned                eff_set_bits;
    int unsigned                eff_block_bits;
    int unsigned                eff_ways;
    int unsigned                hot_sets;
    int unsigned                pool_size;
    logic [slc_pkg::ADDR_W-1:0] tag_pool [16];

    set_assoc_lru_cache_sim_core #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_address       (i_address),
        .i_mode          (i_mode),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_outcome       (o_outcome),
        .o_hit_total     (o_hit_total),
        .o_miss_total    (o_miss_total),
        .o_eviction_total(o_eviction_total),
        .o_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    set_assoc_lru_cache_sim_core_checker #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) lookup_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_address       (i_address),
        .i_mode          (i_mode),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_outcome       (o_outcome),
        .i_hit_total     (o_hit_total),
        .i_miss_total    (o_miss_total),
        .i_eviction_total(o_eviction_total),
        .i_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (lookups_pending),
        .o_checked       (results_checked)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // End the run at a generous cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d lookups outstanding",
                 cycle_count, lookups_pending);
        $display("set_assoc_lru_cache_sim_core: mismatch");
        $finish;
    end

    // Stall the result channel in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0)
                    i_out_stall <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10);
                i_out_stall <= 1'b1;
            end
        end
    end

    // Send one access item, with an optional idle burst first; returns at the
    // edge that takes it
    task automatic send_item(input logic [slc_pkg::ADDR_W-1:0] addr,
                             input logic [slc_pkg::MODE_W-1:0] mode);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_address  <= addr;
        i_mode     <= mode;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Hold the input low until every lookup result is in, then let the block
    // settle in case the last item gave none
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (lookups_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [slc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slc_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // Write all three registers and note the clamped shape
    task automatic configure(input logic [slc_pkg::CFG_DATA_W-1:0] set_val,
                             input logic [slc_pkg::CFG_DATA_W-1:0] block_val,
                             input logic [slc_pkg::CFG_DATA_W-1:0] ways_val);
        write_reg(slc_pkg::CFG_SET_BITS, set_val);
        write_reg(slc_pkg::CFG_BLOCK_BITS, block_val);
        write_reg(slc_pkg::CFG_WAYS, ways_val);
        i_cfg_we       <= 1'b0;
        eff_set_bits   = 32'(set_val & 6'h07);
        eff_set_bits   = (eff_set_bits < 1) ? 1 :
                         (eff_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : eff_set_bits;
        eff_block_bits = (block_val < 1) ? 1 : 32'(block_val);
        eff_ways       = 32'(ways_val & 6'h0F);
        eff_ways       = (eff_ways < 1) ? 1 : (eff_ways > MAX_WAYS) ? MAX_WAYS : eff_ways;
        shapes_run++;
    endtask

    // Mostly pool tags over hot sets, now and then a fully random address
    function automatic logic [slc_pkg::ADDR_W-1:0] pick_address();
        logic [slc_pkg::ADDR_W-1:0] offset;
        logic [slc_pkg::ADDR_W-1:0] set_part;
        logic [slc_pkg::ADDR_W-1:0] tag_part;
        int unsigned                shift;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        shift    = eff_set_bits + eff_block_bits;
        offset   = {$urandom, $urandom} & ((64'd1 << eff_block_bits) - 64'd1);
        set_part = 64'($urandom_range(0, hot_sets - 1)) << eff_block_bits;
        tag_part = (shift >= slc_pkg::ADDR_W) ? '0 :
                   tag_pool[$urandom_range(0, pool_size - 1)] << shift;
        return tag_part | set_part | offset;
    endfunction

    initial begin
        logic [slc_pkg::CFG_DATA_W-1:0] set_val;
        logic [slc_pkg::CFG_DATA_W-1:0] block_val;
        logic [slc_pkg::CFG_DATA_W-1:0] ways_val;
        logic [slc_pkg::MODE_W-1:0]     mode;
        int unsigned                    pick;
        int unsigned                    phase_len;

        // Hold reset, then release it
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Small cache, two ways: fills, hits, modify, ignored fetch, eviction
        write_reg(CFG_UNUSED, 6'h3F);
        configure(6'd2, 6'd4, 6'd2);
        send_item(64'h0, slc_pkg::MODE_LOAD);
        send_item(64'h8, slc_pkg::MODE_LOAD);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, slc_pkg::MODE_STORE);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, slc_pkg::MODE_MODIFY);
        send_item(64'h1000, slc_pkg::MODE_IFETCH);
        send_item(64'h40, slc_pkg::MODE_LOAD);
        send_item(64'h80, slc_pkg::MODE_STORE);
        send_item(64'hC0, slc_pkg::MODE_MODIFY);
        send_item(64'h0, slc_pkg::MODE_LOAD);
        send_item(64'h40, slc_pkg::MODE_LOAD);
        drain_results();

        // Zero in every register acts as one
        configure(6'd0, 6'd0, 6'd0);
        send_item(64'h0, slc_pkg::MODE_LOAD);
        send_item(64'h2, slc_pkg::MODE_LOAD);
        send_item(64'h4, slc_pkg::MODE_LOAD);
        send_item(64'h0, slc_pkg::MODE_MODIFY);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, slc_pkg::MODE_IFETCH);
        drain_results();

        // Values above range clamp; offset and set cover the whole address, tag 0
        configure(6'd7, 6'd63, 6'd15);
        send_item(64'h8000_0000_0000_0000, slc_pkg::MODE_LOAD);
        send_item(64'h0, slc_pkg::MODE_LOAD);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, slc_pkg::MODE_STORE);
        send_item(64'h5555_5555_5555_5555, slc_pkg::MODE_MODIFY);
        drain_results();

        // Tag of a single bit
        configure(6'd6, 6'd57, 6'd8);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, slc_pkg::MODE_LOAD);
        send_item(64'h7E00_0000_0000_0000, slc_pkg::MODE_LOAD);
        drain_results();

        // Random phases, each with its own shape and address pool
        while (items_sent < TARGET_ITEMS) begin
            idle_en = (items_sent < TARGET_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                set_val   = 6'($urandom_range(0, 63));
                block_val = 6'($urandom_range(0, 63));
                ways_val  = 6'($urandom_range(0, 63));
            end else begin
                set_val   = 6'($urandom_range(1, MAX_SET_BITS));
                block_val = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(13, 63))
                                                        : 6'($urandom_range(1, 12));
                ways_val  = 6'($urandom_range(1, MAX_WAYS));
            end
            configure(set_val, block_val, ways_val);
            hot_sets  = $urandom_range(1, 4);
            if (hot_sets > (1 << eff_set_bits))
                hot_sets = 1 << eff_set_bits;
            pool_size = eff_ways + $urandom_range(1, 3);
            for (int i = 0; i < pool_size; i++)
                tag_pool[i] = ($urandom_range(0, 1) == 0) ? 64'(i) : {$urandom, $urandom};
            phase_len = $urandom_range(40, 120);
            repeat (phase_len) begin
                pick = $urandom_range(0, 9);
                mode = (pick < 3) ? slc_pkg::MODE_LOAD : (pick < 6) ? slc_pkg::MODE_STORE :
                       (pick < 9) ? slc_pkg::MODE_MODIFY : slc_pkg::MODE_IFETCH;
                send_item(pick_address(), mode);
            end
            drain_results();
        end

        $display("Sent %0d access items, fetches included, over %0d cache shapes;",
                 items_sent, shapes_run);
        $display("checked %0d lookup results in %0d cycles.", results_checked, cycle_count);
        if (fail_count == 0)
            $display("set_assoc_lru_cache_sim_core: match");
        else
            $display("set_assoc_lru_cache_sim_core: mismatch");
        $finish;
    end

endmodule
